>>> rtl/rgst_pkg.sv
package rgst_pkg;

  localparam int LEAF_BITS  = 10;
  localparam int LEAVES     = 1 << LEAF_BITS;
  localparam int NODE_BITS  = LEAF_BITS + 1;
  localparam int NODES      = 1 << NODE_BITS;
  localparam int VALUE_BITS = 32;
  localparam int SHIFT_BITS = $clog2(VALUE_BITS);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [NODE_BITS-1:0]  node_t;

  typedef enum logic [1:0] {
    REQ_UPDATE = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_GET    = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_U_RDL,
    ST_U_RDR,
    ST_U_START,
    ST_U_WAIT,
    ST_Q_CHK,
    ST_Q_START,
    ST_Q_WAIT,
    ST_G_RD,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic   start;
    value_t a;
    value_t b;
  } gcd_req_t;

  typedef struct packed {
    logic   busy;
    logic   done;
    value_t res;
  } gcd_rsp_t;

endpackage

>>> rtl/rgst_if.sv
interface rgst_req_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      req_type;
  logic [rgst_pkg::LEAF_BITS-1:0]  index;
  logic [31:0]                     value;
  logic [rgst_pkg::LEAF_BITS:0]    left;
  logic [rgst_pkg::LEAF_BITS:0]    right;
  modport source (output valid, req_type, index, value, left, right, input ready);
  modport sink (input valid, req_type, index, value, left, right, output ready);
endinterface

interface rgst_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result;
  modport source (output valid, result, input ready);
  modport sink (input valid, result, output ready);
endinterface

>>> rtl/range_gcd_segment_tree.sv
// get reads one leaf; update writes the leaf, then for about 10 levels reads both
// children, runs the gcd and writes the parent; query makes up to about 20 node
// visits, each a check, a gcd start and a wait; gcd is binary, one step a cycle
// shared gcd, 1R1W memory; one request at a time, the next taken while a result waits
// reset: synchronous active-low; a clearing pass then zeroes all 2048 nodes,
// one per cycle, before the first request is taken
module range_gcd_segment_tree (
  input  logic             clk,
  input  logic             rst_n,
  rgst_req_if.sink         in_req,
  rgst_rsp_if.source       out_rsp
);

  localparam int L = rgst_pkg::LEAF_BITS;
  localparam int N = rgst_pkg::NODE_BITS;

  rgst_pkg::value_t   mem [rgst_pkg::NODES];
  rgst_pkg::value_t   rdata_r;
  rgst_pkg::node_t    raddr, waddr;
  rgst_pkg::value_t   wdata;
  logic               we;

  rgst_pkg::state_t   state_r, state_nxt;
  rgst_pkg::node_t    k_r, k_nxt, clr_r, clr_nxt;
  logic [N:0]         l_r, l_nxt, r_r, r_nxt;
  rgst_pkg::value_t   acc_r, acc_nxt, opa_r, opa_nxt, out_data_r, out_data_nxt;
  logic               out_valid_r, out_valid_nxt;

  rgst_pkg::gcd_req_t greq;
  rgst_pkg::gcd_rsp_t grsp;

  logic               acc_in;
  logic [L:0]         hi_sat;

  rgst_gcd u_gcd (.clk(clk), .rst_n(rst_n), .req(greq), .rsp(grsp));

  assign in_req.ready   = (state_r == rgst_pkg::ST_IDLE);
  assign acc_in         = in_req.valid && in_req.ready;
  assign hi_sat         = (in_req.right > (L+1)'(rgst_pkg::LEAVES)) ?
                          (L+1)'(rgst_pkg::LEAVES) : in_req.right;
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.result = out_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      rgst_pkg::ST_CLEAR:   if (clr_r == '1) state_nxt = rgst_pkg::ST_IDLE;
      rgst_pkg::ST_IDLE: begin
        if (acc_in) begin
          case (rgst_pkg::req_type_t'(in_req.req_type))
            rgst_pkg::REQ_UPDATE: state_nxt = rgst_pkg::ST_U_RDL;
            rgst_pkg::REQ_QUERY:  state_nxt = (in_req.left < hi_sat) ?
                                              rgst_pkg::ST_Q_CHK : rgst_pkg::ST_FIN;
            rgst_pkg::REQ_GET:    state_nxt = rgst_pkg::ST_G_RD;
            default:              state_nxt = rgst_pkg::ST_IDLE;
          endcase
        end
      end
      rgst_pkg::ST_U_RDL:   state_nxt = rgst_pkg::ST_U_RDR;
      rgst_pkg::ST_U_RDR:   state_nxt = rgst_pkg::ST_U_START;
      rgst_pkg::ST_U_START: state_nxt = rgst_pkg::ST_U_WAIT;
      rgst_pkg::ST_U_WAIT: begin
        if (grsp.done) begin
          state_nxt = (k_r == N'(1)) ? rgst_pkg::ST_IDLE : rgst_pkg::ST_U_RDL;
        end
      end
      rgst_pkg::ST_Q_CHK: begin
        if (l_r >= r_r) begin
          state_nxt = rgst_pkg::ST_FIN;
        end else if (l_r[0] || r_r[0]) begin
          state_nxt = rgst_pkg::ST_Q_START;
        end
      end
      rgst_pkg::ST_Q_START: state_nxt = rgst_pkg::ST_Q_WAIT;
      rgst_pkg::ST_Q_WAIT:  if (grsp.done) state_nxt = rgst_pkg::ST_Q_CHK;
      rgst_pkg::ST_G_RD:    state_nxt = rgst_pkg::ST_FIN;
      rgst_pkg::ST_FIN:     if (!out_valid_r || out_rsp.ready) state_nxt = rgst_pkg::ST_IDLE;
      default:              state_nxt = rgst_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    k_nxt         = k_r;
    clr_nxt       = clr_r;
    l_nxt         = l_r;
    r_nxt         = r_r;
    acc_nxt       = acc_r;
    opa_nxt       = opa_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_rsp.ready;
    we            = 1'b0;
    waddr         = k_r;
    wdata         = grsp.res;
    raddr         = k_r;
    greq.start    = 1'b0;
    greq.a        = acc_r;
    greq.b        = rdata_r;
    case (state_r)
      rgst_pkg::ST_CLEAR: begin
        we      = 1'b1;
        waddr   = clr_r;
        wdata   = '0;
        clr_nxt = clr_r + 1'b1;
      end
      rgst_pkg::ST_IDLE: begin
        raddr   = {1'b1, in_req.index};
        acc_nxt = '0;
        l_nxt   = (N+1)'(in_req.left) + (N+1)'(rgst_pkg::LEAVES);
        r_nxt   = (N+1)'(hi_sat) + (N+1)'(rgst_pkg::LEAVES);
        k_nxt   = {1'b1, in_req.index};
        if (acc_in && in_req.req_type == rgst_pkg::REQ_UPDATE) begin
          we    = 1'b1;
          waddr = {1'b1, in_req.index};
          wdata = in_req.value;
        end
      end
      rgst_pkg::ST_U_RDL: begin
        k_nxt = k_r >> 1;
        raddr = {k_r[N-1:1], 1'b0};
      end
      rgst_pkg::ST_U_RDR: begin
        raddr   = {k_r[N-2:0], 1'b1};
        opa_nxt = rdata_r;
      end
      rgst_pkg::ST_U_START: begin
        greq.start = 1'b1;
        greq.a     = opa_r;
      end
      rgst_pkg::ST_U_WAIT: begin
        we = grsp.done;
      end
      rgst_pkg::ST_Q_CHK: begin
        if (l_r < r_r) begin
          if (l_r[0]) begin
            raddr = l_r[N-1:0];
            l_nxt = l_r + 1'b1;
          end else if (r_r[0]) begin
            raddr = N'(r_r - 1'b1);
            r_nxt = r_r - 1'b1;
          end else begin
            l_nxt = l_r >> 1;
            r_nxt = r_r >> 1;
          end
        end
      end
      rgst_pkg::ST_Q_START: begin
        greq.start = 1'b1;
      end
      rgst_pkg::ST_Q_WAIT: begin
        if (grsp.done) acc_nxt = grsp.res;
      end
      rgst_pkg::ST_G_RD: begin
        acc_nxt = rdata_r;
      end
      rgst_pkg::ST_FIN: begin
        if (!out_valid_r || out_rsp.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = acc_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rgst_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
    k_r        <= k_nxt;
    l_r        <= l_nxt;
    r_r        <= r_nxt;
    acc_r      <= acc_nxt;
    opa_r      <= opa_nxt;
    out_data_r <= out_data_nxt;
  end

`ifndef ASSERT_OFF
  a_ready_gcd_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.ready |-> !grsp.busy)
    else $error("request taken while gcd unit busy");

  a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    grsp.done |-> (state_r == rgst_pkg::ST_U_WAIT || state_r == rgst_pkg::ST_Q_WAIT))
    else $error("gcd finished outside a wait state");

  a_clear_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rgst_pkg::ST_CLEAR |-> !out_valid_r)
    else $error("result during clearing pass");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == rgst_pkg::ST_Q_START |-> $past(l_r) < $past(r_r))
    else $error("query node visited with empty bounds");
`endif

endmodule

>>> rtl/rgst_gcd.sv
module rgst_gcd (
  input  logic               clk,
  input  logic               rst_n,
  input  rgst_pkg::gcd_req_t req,
  output rgst_pkg::gcd_rsp_t rsp
);

  rgst_pkg::value_t                    a_r, a_nxt, b_r, b_nxt, res_r, res_nxt;
  logic [rgst_pkg::SHIFT_BITS-1:0]     sh_r, sh_nxt;
  logic                                busy_r, busy_nxt, done_r, done_nxt;

  always_comb begin
    a_nxt    = a_r;
    b_nxt    = b_r;
    sh_nxt   = sh_r;
    res_nxt  = res_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      a_nxt    = req.a;
      b_nxt    = req.b;
      sh_nxt   = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (a_r == '0) begin
        res_nxt  = b_r << sh_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (b_r == '0) begin
        res_nxt  = a_r << sh_r;
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else if (!a_r[0] && !b_r[0]) begin
        a_nxt  = a_r >> 1;
        b_nxt  = b_r >> 1;
        sh_nxt = sh_r + 1'b1;
      end else if (!a_r[0]) begin
        a_nxt = a_r >> 1;
      end else if (!b_r[0]) begin
        b_nxt = b_r >> 1;
      end else if (a_r >= b_r) begin
        a_nxt = (a_r - b_r) >> 1;
      end else begin
        b_nxt = (b_r - a_r) >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    sh_r  <= sh_nxt;
    res_r <= res_nxt;
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.res  = res_r;

endmodule
